// ===== hw/rtl/banked_register_file_mode_switch_macros.svh =====
// Assertion helpers for the banked register file.
// Both forms sample on the rising edge of clock and are off during reset.
`ifndef BANKED_REGISTER_FILE_MODE_SWITCH_MACROS_SVH
`define BANKED_REGISTER_FILE_MODE_SWITCH_MACROS_SVH

// cond must hold at every edge.
`define BRFMS_ASSERT_ALWAYS(label, cond, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond)) else $error(msg);

// When ante holds, cons must hold at the next edge.
`define BRFMS_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== hw/rtl/brfms_pkg.sv =====
package brfms_pkg;

   typedef enum logic [2:0] {
      MODE_USER       = 3'd0,
      MODE_FIQ        = 3'd1,
      MODE_IRQ        = 3'd2,
      MODE_SUPERVISOR = 3'd3,
      MODE_ABORT      = 3'd4,
      MODE_UNDEFINED  = 3'd5,
      MODE_SYSTEM     = 3'd6
   } mode_type;

   typedef enum logic [2:0] {
      CMD_READ_REG    = 3'd0,
      CMD_WRITE_REG   = 3'd1,
      CMD_READ_SAVED  = 3'd2,
      CMD_WRITE_SAVED = 3'd3,
      CMD_WRITE_STAT  = 3'd4,
      CMD_EXC_ENTRY   = 3'd5,
      CMD_IRQ_ENTRY   = 3'd6
   } cmd_type;

   // status word mode field encodings
   localparam logic [4:0] MODE_BITS_USER       = 5'h10;
   localparam logic [4:0] MODE_BITS_FIQ        = 5'h11;
   localparam logic [4:0] MODE_BITS_IRQ        = 5'h12;
   localparam logic [4:0] MODE_BITS_SUPERVISOR = 5'h13;
   localparam logic [4:0] MODE_BITS_ABORT      = 5'h17;
   localparam logic [4:0] MODE_BITS_UNDEFINED  = 5'h1B;
   localparam logic [4:0] MODE_BITS_SYSTEM     = 5'h1F;

   localparam int unsigned THUMB_BIT  = 5;
   localparam int unsigned IRQOFF_BIT = 7;

   localparam logic [31:0] R0_RESET     = 32'h0800_0000;
   localparam logic [31:0] R1_RESET     = 32'h0000_00EA;
   localparam logic [31:0] STACK_RESET  = 32'h0300_7F00;
   localparam logic [31:0] STATUS_RESET = 32'h6000_001F;
   localparam logic [31:0] PC_RESET     = 32'h0800_0000;
   localparam logic [31:0] IRQ_VECTOR   = 32'h0000_0018;

   typedef struct packed {
      logic     valid;
      mode_type code;
   } mode_dec_type;

   // current state as seen by the command logic
   typedef struct packed {
      logic [31:0] status;
      logic [31:0] pc;
      mode_type    mode;
      logic [31:0] reg_rd;    // register at the item's index, current view
      logic [31:0] saved_rd;  // saved status of the current mode
   } view_type;

   // state updates for one item
   typedef struct packed {
      logic        reg_we;
      logic [3:0]  reg_idx;
      logic [31:0] reg_data;
      logic        saved_we;
      mode_type    saved_sel;
      logic [31:0] saved_data;
      logic        link_we;
      mode_type    link_sel;
      logic [31:0] link_data;
      logic        status_we;
      logic [31:0] status_data;
      logic        pc_we;
      logic [31:0] pc_data;
   } wr_type;

   function automatic mode_dec_type mode_decode(input logic [4:0] bits);
      mode_dec_type d;
      d.valid = 1'b1;
      case (bits)
         MODE_BITS_USER:       d.code = MODE_USER;
         MODE_BITS_FIQ:        d.code = MODE_FIQ;
         MODE_BITS_IRQ:        d.code = MODE_IRQ;
         MODE_BITS_SUPERVISOR: d.code = MODE_SUPERVISOR;
         MODE_BITS_ABORT:      d.code = MODE_ABORT;
         MODE_BITS_UNDEFINED:  d.code = MODE_UNDEFINED;
         MODE_BITS_SYSTEM:     d.code = MODE_SYSTEM;
         default: begin
            d.valid = 1'b0;
            d.code  = MODE_USER;
         end
      endcase
      return d;
   endfunction

   // exception modes own a saved status word
   function automatic logic has_saved(input mode_type m);
      return (m != MODE_USER) && (m != MODE_SYSTEM);
   endfunction

endpackage

// ===== hw/rtl/brfms_if.sv =====
interface brfms_req_if;
   logic        valid;
   logic        ready;
   logic [2:0]  cmd;
   logic [3:0]  reg_index;
   logic [31:0] write_data;
   logic [4:0]  exception_mode;

   modport source (output valid, cmd, reg_index, write_data, exception_mode, input ready);
   modport sink (input valid, cmd, reg_index, write_data, exception_mode, output ready);
endinterface

interface brfms_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] read_data;
   logic        mode_error;
   logic [2:0]  current_mode;
   logic        thumb_state;
   logic        privileged;
   logic        has_saved_status;

   modport source (output valid, read_data, mode_error, current_mode, thumb_state,
                   privileged, has_saved_status, input ready);
   modport sink (input valid, read_data, mode_error, current_mode, thumb_state,
                 privileged, has_saved_status, output ready);
endinterface

// ===== hw/rtl/banked_register_file_mode_switch.sv =====
// Mode-banked register file of an ARM7-class core.
//
// req_ch carries one command per transfer: register read/write, saved status
// read/write, status word write, exception entry or IRQ entry. rsp_ch returns
// exactly one result per command: the read value (zero for non-reads), a
// mode error flag, and the mode, thumb bit and privilege view after it.
// Both channels use valid/ready; a transfer happens when both are high.
//
// A command passes first through the input register, then the result
// register, whose valid bit drives rsp_ch.valid. The command executes as it
// moves from the input register to the result register, so the next command
// already sees its updates. One command per cycle is sustained while
// rsp_ch.ready stays high.
// When rsp_ch.ready is low the result holds, the input register holds its
// command, and req_ch.ready drops once that register is full.
//
// Synchronous reset empties both registers and loads the architectural reset
// values: r0 0x08000000, r1 0xEA, every r13 0x03007F00, status 0x6000001F
// (system mode), pc 0x08000000, all else zero.
module banked_register_file_mode_switch
   import brfms_pkg::*;
(
   input logic        clock,
   input logic        reset,
   brfms_req_if.sink   req_ch,
   brfms_rsp_if.source rsp_ch
);

`include "banked_register_file_mode_switch_macros.svh"

   // input register
   logic        in_valid_ff;
   logic [2:0]  in_cmd_ff;
   logic [3:0]  in_idx_ff;
   logic [31:0] in_data_ff;
   logic [4:0]  in_emode_ff;

   // result register
   logic        out_valid_ff;
   logic        out_valid_in;
   logic [31:0] out_read_data_ff;
   logic        out_mode_error_ff;
   mode_type    out_mode_ff;
   logic        out_thumb_ff;

   logic        advance;
   view_type    view;
   wr_type      wr;
   logic [31:0] read_data;
   logic        mode_error;
   mode_type    next_mode;
   logic        next_thumb;

   // command executes when the result slot is free or emptying this cycle
   assign advance      = in_valid_ff && (!out_valid_ff || rsp_ch.ready);
   assign req_ch.ready = !in_valid_ff || advance;
   assign out_valid_in = advance || (out_valid_ff && !rsp_ch.ready);

   brfms_bank u_bank (
      .clock  (clock),
      .reset  (reset),
      .commit (advance),
      .rd_idx (in_idx_ff),
      .wr     (wr),
      .view   (view)
   );

   brfms_exec u_exec (
      .cmd            (in_cmd_ff),
      .reg_index      (in_idx_ff),
      .write_data     (in_data_ff),
      .exception_mode (in_emode_ff),
      .view           (view),
      .wr             (wr),
      .read_data      (read_data),
      .mode_error     (mode_error),
      .next_mode      (next_mode),
      .next_thumb     (next_thumb)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (req_ch.ready) in_valid_ff <= req_ch.valid;
         out_valid_ff <= out_valid_in;
      end
      // payload, no reset
      if (req_ch.ready && req_ch.valid) begin
         in_cmd_ff   <= req_ch.cmd;
         in_idx_ff   <= req_ch.reg_index;
         in_data_ff  <= req_ch.write_data;
         in_emode_ff <= req_ch.exception_mode;
      end
      if (advance) begin
         out_read_data_ff  <= read_data;
         out_mode_error_ff <= mode_error;
         out_mode_ff       <= next_mode;
         out_thumb_ff      <= next_thumb;
      end
   end

   assign rsp_ch.valid            = out_valid_ff;
   assign rsp_ch.read_data        = out_read_data_ff;
   assign rsp_ch.mode_error       = out_mode_error_ff;
   assign rsp_ch.current_mode     = 3'(out_mode_ff);
   assign rsp_ch.thumb_state      = out_thumb_ff;
   assign rsp_ch.privileged       = (out_mode_ff != MODE_USER);
   assign rsp_ch.has_saved_status = has_saved(out_mode_ff);

   // ignored commands never return data
   `BRFMS_ASSERT_ALWAYS(a_err_no_data,
      !(out_valid_ff && out_mode_error_ff) || (out_read_data_ff == 32'd0),
      "mode error with nonzero read data")

   // a mode with saved status is always privileged
   `BRFMS_ASSERT_ALWAYS(a_saved_priv,
      !(out_valid_ff && rsp_ch.has_saved_status) || rsp_ch.privileged,
      "saved status flagged in unprivileged mode")

   // IRQ entry lands in IRQ mode, ARM state
   `BRFMS_ASSERT_NEXT(a_irq_entry,
      advance && (in_cmd_ff == CMD_IRQ_ENTRY),
      out_valid_ff && (out_mode_ff == MODE_IRQ) && !out_thumb_ff,
      "IRQ entry did not switch to IRQ ARM state")

   // a stalled result register is never overwritten
   `BRFMS_ASSERT_NEXT(a_no_overrun,
      out_valid_ff && !rsp_ch.ready,
      out_valid_ff && $stable(out_read_data_ff) && $stable(out_mode_ff),
      "result overwritten while stalled")

endmodule

// ===== hw/rtl/brfms_bank.sv =====
module brfms_bank
   import brfms_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       commit,
   input  logic [3:0] rd_idx,
   input  wr_type     wr,
   output view_type   view
);

   logic [31:0] low_ff   [13];
   logic [31:0] fiq_ff   [5];
   logic [31:0] stack_ff [6];
   logic [31:0] link_ff  [6];
   logic [31:0] saved_ff [5];
   logic [31:0] status_ff;
   logic [31:0] pc_ff;

   mode_dec_type dec;
   mode_type     mode;
   logic [2:0]   bank;
   logic [2:0]   wbank;
   logic [2:0]   saved_rd_sel;
   logic [2:0]   saved_wr_sel;

   always_comb begin
      dec  = mode_decode(status_ff[4:0]);
      mode = dec.valid ? dec.code : MODE_USER;
      // system mode shares the user stack/link bank
      bank = (mode == MODE_SYSTEM) ? 3'd0 : 3'(mode);
      wbank = 3'(wr.link_sel);
      saved_rd_sel = 3'(mode) - 3'd1;
      saved_wr_sel = 3'(wr.saved_sel) - 3'd1;
   end

   always_comb begin
      view.status = status_ff;
      view.pc     = pc_ff;
      view.mode   = mode;
      if (rd_idx == 4'd15)
         view.reg_rd = pc_ff;
      else if (rd_idx == 4'd14)
         view.reg_rd = link_ff[bank];
      else if (rd_idx == 4'd13)
         view.reg_rd = stack_ff[bank];
      else if (rd_idx[3] && mode == MODE_FIQ)
         view.reg_rd = fiq_ff[rd_idx[2:0]];
      else
         view.reg_rd = low_ff[rd_idx];
      view.saved_rd = has_saved(mode) ? saved_ff[saved_rd_sel] : 32'd0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         low_ff[0] <= R0_RESET;
         low_ff[1] <= R1_RESET;
         for (int i = 2; i < 13; i++) low_ff[i] <= 32'd0;
         for (int i = 0; i < 5; i++) fiq_ff[i] <= 32'd0;
         for (int i = 0; i < 6; i++) stack_ff[i] <= STACK_RESET;
         for (int i = 0; i < 6; i++) link_ff[i] <= 32'd0;
         for (int i = 0; i < 5; i++) saved_ff[i] <= 32'd0;
         status_ff <= STATUS_RESET;
         pc_ff     <= PC_RESET;
      end else if (commit) begin
         if (wr.reg_we) begin
            if (wr.reg_idx == 4'd15)
               pc_ff <= wr.reg_data;
            else if (wr.reg_idx == 4'd14)
               link_ff[bank] <= wr.reg_data;
            else if (wr.reg_idx == 4'd13)
               stack_ff[bank] <= wr.reg_data;
            else if (wr.reg_idx[3] && mode == MODE_FIQ)
               fiq_ff[wr.reg_idx[2:0]] <= wr.reg_data;
            else
               low_ff[wr.reg_idx] <= wr.reg_data;
         end
         if (wr.link_we) link_ff[wbank] <= wr.link_data;
         if (wr.saved_we) saved_ff[saved_wr_sel] <= wr.saved_data;
         if (wr.status_we) status_ff <= wr.status_data;
         if (wr.pc_we) pc_ff <= wr.pc_data;
      end
   end

endmodule

// ===== hw/rtl/brfms_exec.sv =====
module brfms_exec
   import brfms_pkg::*;
(
   input  logic [2:0]  cmd,
   input  logic [3:0]  reg_index,
   input  logic [31:0] write_data,
   input  logic [4:0]  exception_mode,
   input  view_type    view,
   output wr_type      wr,
   output logic [31:0] read_data,
   output logic        mode_error,
   output mode_type    next_mode,
   output logic        next_thumb
);

   logic         thumb;
   mode_dec_type wdec;
   mode_dec_type edec;
   logic [31:0]  entry_status;
   logic [31:0]  status_after;
   mode_dec_type adec;

   always_comb begin
      thumb = view.status[THUMB_BIT];
      wdec  = mode_decode(write_data[4:0]);
      edec  = mode_decode(exception_mode);
      // entry: clear thumb, mask IRQ; mode bits patched below
      entry_status = view.status;
      entry_status[THUMB_BIT]  = 1'b0;
      entry_status[IRQOFF_BIT] = 1'b1;

      wr = '0;
      wr.reg_idx  = reg_index;
      wr.reg_data = write_data;
      read_data  = 32'd0;
      mode_error = 1'b0;

      case (cmd)
         CMD_READ_REG: read_data = view.reg_rd;
         CMD_WRITE_REG: wr.reg_we = 1'b1;
         CMD_READ_SAVED: read_data = has_saved(view.mode) ? view.saved_rd : view.status;
         CMD_WRITE_SAVED: begin
            wr.saved_we   = has_saved(view.mode);
            wr.saved_sel  = view.mode;
            wr.saved_data = write_data;
         end
         CMD_WRITE_STAT: begin
            if (!wdec.valid) mode_error = 1'b1;
            else begin
               wr.status_we   = 1'b1;
               wr.status_data = write_data;
            end
         end
         CMD_EXC_ENTRY: begin
            if (!edec.valid || !has_saved(edec.code)) mode_error = 1'b1;
            else begin
               wr.link_we     = 1'b1;
               wr.link_sel    = edec.code;
               wr.link_data   = view.pc - (thumb ? 32'd2 : 32'd4);
               wr.saved_we    = 1'b1;
               wr.saved_sel   = edec.code;
               wr.saved_data  = view.status;
               wr.status_we   = 1'b1;
               wr.status_data = {entry_status[31:5], exception_mode};
            end
         end
         CMD_IRQ_ENTRY: begin
            // pc - (thumb ? 4 : 8) + 4
            wr.link_we     = 1'b1;
            wr.link_sel    = MODE_IRQ;
            wr.link_data   = view.pc - (thumb ? 32'd0 : 32'd4);
            wr.saved_we    = 1'b1;
            wr.saved_sel   = MODE_IRQ;
            wr.saved_data  = view.status;
            wr.status_we   = 1'b1;
            wr.status_data = {entry_status[31:5], MODE_BITS_IRQ};
            wr.pc_we       = 1'b1;
            wr.pc_data     = IRQ_VECTOR;
         end
         default: ;
      endcase

      status_after = wr.status_we ? wr.status_data : view.status;
      adec         = mode_decode(status_after[4:0]);
      next_mode    = adec.valid ? adec.code : MODE_USER;
      next_thumb   = status_after[THUMB_BIT];
   end

endmodule

// ===== sim/brfms_checker.sv =====
`timescale 1ns / 1ps
// Watches both channels, keeps its own copy of the register file state and
// compares every result transfer with the oldest predicted access result.
module brfms_checker
   import brfms_pkg::*;
(
   input  logic  clock,
   input  logic  reset,
   brfms_req_if  req,
   brfms_rsp_if  rsp,
   output int    fail_count,
   output int    pending,
   output int    checked,
   output int    flagged
);

   typedef struct packed {
      logic [31:0] read_data;
      logic        mode_error;
      logic [2:0]  current_mode;
      logic        thumb_state;
      logic        privileged;
      logic        has_saved_status;
   } access_result_type;

   logic [31:0] low_bank [13];   // r0-r7, and r8-r12 outside FIQ
   logic [31:0] fiq_bank [5];    // r8-r12 in FIQ
   logic [31:0] sp_bank [6];     // r13, index 0 user/system
   logic [31:0] lr_bank [6];     // r14, same banking
   logic [31:0] spsr_bank [5];   // fiq..undefined
   logic [31:0] cpsr;
   logic [31:0] pc;

   access_result_type access_results [$];
   int mismatches;
   int result_count;
   int error_count;

   function automatic logic decode_mode(input logic [4:0] bits, output mode_type m);
      m = MODE_USER;
      case (bits)
         MODE_BITS_USER:       m = MODE_USER;
         MODE_BITS_FIQ:        m = MODE_FIQ;
         MODE_BITS_IRQ:        m = MODE_IRQ;
         MODE_BITS_SUPERVISOR: m = MODE_SUPERVISOR;
         MODE_BITS_ABORT:      m = MODE_ABORT;
         MODE_BITS_UNDEFINED:  m = MODE_UNDEFINED;
         MODE_BITS_SYSTEM:     m = MODE_SYSTEM;
         default:              return 1'b0;
      endcase
      return 1'b1;
   endfunction

   function automatic mode_type active_mode();
      mode_type m;
      if (!decode_mode(cpsr[4:0], m)) m = MODE_USER;
      return m;
   endfunction

   function automatic logic owns_spsr(input mode_type m);
      return (m != MODE_USER) && (m != MODE_SYSTEM);
   endfunction

   function automatic int stack_bank(input mode_type m);
      return (m == MODE_SYSTEM) ? 0 : int'(m);
   endfunction

   // one register of the current view; returns the old value, writes if asked
   task automatic access_reg(input mode_type m, input logic [3:0] idx, input logic wr,
                             input logic [31:0] data, output logic [31:0] rd);
      int b;
      b = stack_bank(m);
      if (idx == 4'd15) begin
         rd = pc;
         if (wr) pc = data;
      end else if (idx == 4'd14) begin
         rd = lr_bank[b];
         if (wr) lr_bank[b] = data;
      end else if (idx == 4'd13) begin
         rd = sp_bank[b];
         if (wr) sp_bank[b] = data;
      end else if (idx >= 4'd8 && m == MODE_FIQ) begin
         rd = fiq_bank[idx - 4'd8];
         if (wr) fiq_bank[idx - 4'd8] = data;
      end else begin
         rd = low_bank[idx];
         if (wr) low_bank[idx] = data;
      end
   endtask

   task automatic enter_exception(input mode_type t, input logic [4:0] bits,
                                  input logic [31:0] link);
      lr_bank[int'(t)] = link;
      spsr_bank[int'(t) - 1] = cpsr;
      cpsr[4:0] = bits;
      cpsr[THUMB_BIT] = 1'b0;
      cpsr[IRQOFF_BIT] = 1'b1;
   endtask

   task automatic execute_command(input logic [2:0] cmd, input logic [3:0] idx,
                                  input logic [31:0] data, input logic [4:0] emode);
      access_result_type r;
      mode_type m;
      mode_type t;
      logic thumb;
      logic [31:0] old;
      r = '0;
      m = active_mode();
      thumb = cpsr[THUMB_BIT];
      case (cmd)
         CMD_READ_REG:  access_reg(m, idx, 1'b0, data, r.read_data);
         CMD_WRITE_REG: access_reg(m, idx, 1'b1, data, old);
         CMD_READ_SAVED: r.read_data = owns_spsr(m) ? spsr_bank[int'(m) - 1] : cpsr;
         CMD_WRITE_SAVED: begin
            if (owns_spsr(m)) spsr_bank[int'(m) - 1] = data;
         end
         CMD_WRITE_STAT: begin
            if (decode_mode(data[4:0], t)) cpsr = data;
            else r.mode_error = 1'b1;
         end
         CMD_EXC_ENTRY: begin
            if (decode_mode(emode, t) && owns_spsr(t))
               enter_exception(t, emode, pc - (thumb ? 32'd2 : 32'd4));
            else
               r.mode_error = 1'b1;
         end
         CMD_IRQ_ENTRY: begin
            enter_exception(MODE_IRQ, MODE_BITS_IRQ, pc - (thumb ? 32'd4 : 32'd8) + 32'd4);
            pc = IRQ_VECTOR;
         end
         default: ;
      endcase
      m = active_mode();
      r.current_mode     = m;
      r.thumb_state      = cpsr[THUMB_BIT];
      r.privileged       = (m != MODE_USER);
      r.has_saved_status = owns_spsr(m);
      if (r.mode_error) error_count++;
      access_results.push_back(r);
   endtask

   task automatic report_failure(input string what);
      mismatches++;
      $display("[%0t] mismatch: %s", $time, what);
   endtask

   task automatic compare_field(input string name, input logic [31:0] got,
                                input logic [31:0] want);
      if (got !== want)
         report_failure($sformatf("%s got 0x%08h, want 0x%08h", name, got, want));
   endtask

   always @(posedge clock) begin : track
      access_result_type want;
      if (reset) begin
         foreach (low_bank[i]) low_bank[i] = '0;
         foreach (fiq_bank[i]) fiq_bank[i] = '0;
         foreach (sp_bank[i]) sp_bank[i] = STACK_RESET;
         foreach (lr_bank[i]) lr_bank[i] = '0;
         foreach (spsr_bank[i]) spsr_bank[i] = '0;
         low_bank[0] = R0_RESET;
         low_bank[1] = R1_RESET;
         cpsr = STATUS_RESET;
         pc = PC_RESET;
         access_results.delete();
         mismatches = 0;
         result_count = 0;
         error_count = 0;
      end else begin
         // results always leave after their command's transfer, so check first
         if (rsp.valid && rsp.ready) begin
            if (access_results.size() == 0) begin
               report_failure("result transfer with no command outstanding");
            end else begin
               want = access_results.pop_front();
               compare_field("read_data", rsp.read_data, want.read_data);
               compare_field("mode_error", 32'(rsp.mode_error), 32'(want.mode_error));
               compare_field("current_mode", 32'(rsp.current_mode),
                             32'(want.current_mode));
               compare_field("thumb_state", 32'(rsp.thumb_state), 32'(want.thumb_state));
               compare_field("privileged", 32'(rsp.privileged), 32'(want.privileged));
               compare_field("has_saved_status", 32'(rsp.has_saved_status),
                             32'(want.has_saved_status));
               result_count++;
            end
         end
         if (req.valid && req.ready)
            execute_command(req.cmd, req.reg_index, req.write_data, req.exception_mode);
      end
      fail_count <= mismatches;
      pending    <= access_results.size();
      checked    <= result_count;
      flagged    <= error_count;
   end

endmodule

// ===== sim/tb.sv =====
`timescale 1ns / 1ps
// Top level: clock, reset, command stimulus, result-side stalls, watchdog and
// the verdict. All prediction and comparison lives in brfms_checker.
module tb;
   import brfms_pkg::*;

   // the 3-bit command field has one code the block defines as a no-op
   localparam logic [2:0] CMD_UNUSED = 3'd7;
   localparam int ITEM_COUNT  = 1650;
   localparam int IDLE_LIMIT  = 5000;  // cycles with no transfer on either side
   localparam int TAIL_CYCLES = 8;     // margin after the final drain

   logic clock;
   logic reset;
   int   fail_count;
   int   pending;
   int   checked;
   int   flagged;
   int   sent = 0;
   int   directed_count = 0;
   int   drains = 0;
   int   idle_cycles = 0;

   brfms_req_if req_ch ();
   brfms_rsp_if rsp_ch ();

   banked_register_file_mode_switch dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   brfms_checker u_check (
      .clock      (clock),
      .reset      (reset),
      .req        (req_ch),
      .rsp        (rsp_ch),
      .fail_count (fail_count),
      .pending    (pending),
      .checked    (checked),
      .flagged    (flagged)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Present one command and hold it until the transfer. valid stays high on
   // return so back-to-back calls form a burst with no bubble.
   task automatic issue_command(input logic [2:0] cmd, input logic [3:0] idx,
                                input logic [31:0] data, input logic [4:0] emode);
      req_ch.valid          <= 1'b1;
      req_ch.cmd            <= cmd;
      req_ch.reg_index      <= idx;
      req_ch.write_data     <= data;
      req_ch.exception_mode <= emode;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      sent++;
   endtask

   // pending is updated nonblocking by the checker, so at the next edge after the last
   // transfer it already counts that command
   task automatic wait_for_drain();
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      drains++;
   endtask

   function automatic logic [4:0] pick_mode_bits(input bit exception_only);
      case ($urandom_range(exception_only ? 1 : 0, exception_only ? 5 : 6))
         0:       return MODE_BITS_USER;
         1:       return MODE_BITS_FIQ;
         2:       return MODE_BITS_IRQ;
         3:       return MODE_BITS_SUPERVISOR;
         4:       return MODE_BITS_ABORT;
         5:       return MODE_BITS_UNDEFINED;
         default: return MODE_BITS_SYSTEM;
      endcase
   endfunction

   // Random command mix. Status writes mostly carry legal mode bits so the
   // run keeps moving through all seven modes; entries mostly target real
   // exception modes, with user/system and junk bits mixed in.
   task automatic issue_random_command();
      int pick;
      int sel;
      logic [2:0]  cmd;
      logic [31:0] data;
      logic [4:0]  emode;
      pick = $urandom_range(0, 99);
      if (pick < 22)      cmd = CMD_READ_REG;
      else if (pick < 40) cmd = CMD_WRITE_REG;
      else if (pick < 50) cmd = CMD_READ_SAVED;
      else if (pick < 58) cmd = CMD_WRITE_SAVED;
      else if (pick < 72) cmd = CMD_WRITE_STAT;
      else if (pick < 88) cmd = CMD_EXC_ENTRY;
      else                cmd = CMD_IRQ_ENTRY;
      case ($urandom_range(0, 7))
         0:       data = '0;
         1:       data = '1;
         default: data = $urandom();
      endcase
      if (cmd == CMD_WRITE_STAT && $urandom_range(0, 9) != 0)
         data[4:0] = pick_mode_bits(1'b0);
      emode = 5'($urandom());
      sel = $urandom_range(0, 9);
      if (sel < 8)       emode = pick_mode_bits(1'b1);
      else if (sel == 8) emode = pick_mode_bits(1'b0);
      issue_command(cmd, 4'($urandom_range(0, 15)), data, emode);
   endtask

   // Result side: phases of random length, each with its own stall pattern
   // (always ready, mostly ready, a repeating fixed 8-bit mask, mostly stalled).
   initial begin
      int kind;
      int span;
      logic [7:0] mask;
      rsp_ch.ready <= 1'b0;
      forever begin
         kind = $urandom_range(0, 3);
         span = $urandom_range(20, 200);
         mask = 8'($urandom_range(1, 255));
         for (int c = 0; c < span; c++) begin
            @(posedge clock);
            case (kind)
               0:       rsp_ch.ready <= 1'b1;
               1:       rsp_ch.ready <= ($urandom_range(0, 3) != 0);
               2:       rsp_ch.ready <= mask[c % 8];
               default: rsp_ch.ready <= ($urandom_range(0, 9) < 3);
            endcase
         end
      end
   end

   // Watchdog: any transfer on either channel restarts the count.
   always @(posedge clock) begin
      if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("watchdog: no transfer for %0d cycles, %0d results outstanding",
                  IDLE_LIMIT, pending);
         $display("FAIL");
         $finish;
      end
   end

   initial begin
      int burst;
      int gap;
      int bursts;
      reset                 <= 1'b1;
      req_ch.valid          <= 1'b0;
      req_ch.cmd            <= CMD_READ_REG;
      req_ch.reg_index      <= '0;
      req_ch.write_data     <= '0;
      req_ch.exception_mode <= '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // --- directed walk through reset values, every command and each corner
      issue_command(CMD_READ_REG, 4'd0, 32'h0, 5'h00);               // r0 reset value
      issue_command(CMD_READ_REG, 4'd15, 32'h0, 5'h00);              // pc
      issue_command(CMD_READ_REG, 4'd13, 32'h0, 5'h00);              // shared user/sys stack
      issue_command(CMD_READ_SAVED, 4'd0, 32'h0, 5'h00);             // system: returns status
      issue_command(CMD_WRITE_SAVED, 4'd0, 32'hFFFF_FFFF, 5'h00);    // system: dropped
      issue_command(CMD_WRITE_STAT, 4'd0, 32'h0000_0000, 5'h00);     // bad mode bits
      issue_command(CMD_EXC_ENTRY, 4'd0, 32'h0, MODE_BITS_USER);     // not an exception mode
      issue_command(CMD_EXC_ENTRY, 4'd0, 32'h0, 5'h1F);              // system, all ones
      issue_command(CMD_EXC_ENTRY, 4'd15, 32'hFFFF_FFFF, MODE_BITS_FIQ);
      issue_command(CMD_WRITE_REG, 4'd8, 32'hFFFF_FFFF, 5'h00);      // FIQ-only r8
      issue_command(CMD_READ_REG, 4'd8, 32'h0, 5'h00);
      issue_command(CMD_READ_REG, 4'd14, 32'h0, 5'h00);              // FIQ link
      issue_command(CMD_READ_SAVED, 4'd0, 32'h0, 5'h00);
      issue_command(CMD_WRITE_SAVED, 4'd0, 32'hFFFF_FFFF, 5'h00);
      issue_command(CMD_WRITE_STAT, 4'd0, 32'h0000_0030, 5'h00);     // user, thumb
      issue_command(CMD_READ_REG, 4'd8, 32'h0, 5'h00);               // shared r8 again
      issue_command(CMD_WRITE_REG, 4'd15, 32'h0000_0000, 5'h00);     // pc = 0
      issue_command(CMD_EXC_ENTRY, 4'd0, 32'h0, MODE_BITS_ABORT);    // thumb link wraps
      issue_command(CMD_READ_REG, 4'd14, 32'h0, 5'h00);
      issue_command(CMD_WRITE_STAT, 4'd0, 32'hFFFF_FFFF, 5'h00);     // system, thumb
      issue_command(CMD_IRQ_ENTRY, 4'd0, 32'h0, 5'h00);              // thumb IRQ from pc 0
      issue_command(CMD_READ_REG, 4'd15, 32'h0, 5'h00);              // vector
      issue_command(CMD_WRITE_STAT, 4'd0, 32'h0000_001B, 5'h00);     // undefined
      issue_command(CMD_UNUSED, 4'd15, 32'hFFFF_FFFF, 5'h1F);        // no-op code
      issue_command(CMD_WRITE_STAT, 4'd0, 32'h0000_0013, 5'h00);     // supervisor, ARM
      issue_command(CMD_IRQ_ENTRY, 4'd0, 32'h0, 5'h00);              // ARM IRQ
      issue_command(CMD_READ_SAVED, 4'd0, 32'h0, 5'h00);
      directed_count = sent;
      req_ch.valid <= 1'b0;
      wait_for_drain();

      // --- random bursts; every 20th burst holds off until all results are in
      bursts = 0;
      while (sent < ITEM_COUNT) begin
         burst = $urandom_range(1, 32);
         for (int i = 0; i < burst && sent < ITEM_COUNT; i++) issue_random_command();
         bursts++;
         if (bursts % 20 == 0) begin
            req_ch.valid <= 1'b0;
            wait_for_drain();
         end else begin
            // a quarter of bursts run straight into the next one
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0) begin
               req_ch.valid <= 1'b0;
               repeat (gap) @(posedge clock);
            end
         end
      end
      req_ch.valid <= 1'b0;
      wait_for_drain();
      repeat (TAIL_CYCLES) @(posedge clock);

      $display("Covered %0d commands (%0d directed) over all modes;", sent, directed_count);
      $display("%0d results checked, %0d mode errors, %0d full drains, %0d mismatches.",
               checked, flagged, drains, fail_count);
      if (fail_count == 0 && pending == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule

// ===== files.f =====
+incdir+hw/rtl
hw/rtl/brfms_pkg.sv
hw/rtl/brfms_if.sv
hw/rtl/brfms_bank.sv
hw/rtl/brfms_exec.sv
hw/rtl/banked_register_file_mode_switch.sv
sim/brfms_checker.sv
sim/tb.sv
